@@ rtl/dnv_pkg.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_pkg
// Types and constants shared by the domain name validator.
//------------------------------------------------------------------------------
package dnv_pkg;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_MIN_TOTAL = 2'd0,
		REG_MAX_TOTAL = 2'd1,
		REG_MAX_LABEL = 2'd2,
		REG_MIN_TLD   = 2'd3
	} dnv_reg_t;

	localparam logic [7:0] RST_MIN_TOTAL = 8'd5;
	localparam logic [7:0] RST_MAX_TOTAL = 8'd255;
	localparam logic [5:0] RST_MAX_LABEL = 6'd63;
	localparam logic [5:0] RST_MIN_TLD   = 6'd2;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [8:0] TOTAL_SAT = 9'h1FF;
	localparam logic [6:0] LABEL_SAT = 7'h7F;
	localparam logic [1:0] TALLY_SAT = 2'd3;
	localparam logic [1:0] TALLY_MIN = 2'd2;

	typedef struct packed {
		logic [7:0] min_total_length;
		logic [7:0] max_total_length;
		logic [5:0] max_label_length;
		logic [5:0] min_tld_length;
	} dnv_cfg_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} dnv_word_t;

endpackage

@@ rtl/dnv_ifs.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_ifs
// Ready/valid channels for name characters and verdicts.
//------------------------------------------------------------------------------
interface dnv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink   (input valid, character, last_char, output ready);
endinterface

interface dnv_verdict_if;
	logic valid;
	logic ready;
	logic name_valid;

	modport source (output valid, name_valid, input ready);
	modport sink   (input valid, name_valid, output ready);
endinterface

@@ rtl/dnv_cfg_regs.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_cfg_regs
// APB register file holding the length limits.
//------------------------------------------------------------------------------
module dnv_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dnv_pkg::PADDR_W-1:0]  paddr,
	input  logic [dnv_pkg::PDATA_W-1:0]  pwdata,
	output logic [dnv_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output dnv_pkg::dnv_cfg_t            cfg
);
	import dnv_pkg::*;

	dnv_cfg_t cfg_q;
	dnv_reg_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = dnv_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_total_length <= RST_MIN_TOTAL;
			cfg_q.max_total_length <= RST_MAX_TOTAL;
			cfg_q.max_label_length <= RST_MAX_LABEL;
			cfg_q.min_tld_length   <= RST_MIN_TLD;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_TOTAL: cfg_q.min_total_length <= pwdata[7:0];
				REG_MAX_TOTAL: cfg_q.max_total_length <= pwdata[7:0];
				REG_MAX_LABEL: cfg_q.max_label_length <= pwdata[5:0];
				REG_MIN_TLD:   cfg_q.min_tld_length   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_MIN_TOTAL: prdata = {24'd0, cfg_q.min_total_length};
			REG_MAX_TOTAL: prdata = {24'd0, cfg_q.max_total_length};
			REG_MAX_LABEL: prdata = {26'd0, cfg_q.max_label_length};
			REG_MIN_TLD:   prdata = {26'd0, cfg_q.min_tld_length};
			default:       prdata = '0;
		endcase
	end

endmodule

@@ rtl/dnv_name_check.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_name_check
// Per-name state: counts, label tracking and the verdict of the last word.
//------------------------------------------------------------------------------
module dnv_name_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dnv_pkg::dnv_word_t word,
	input  dnv_pkg::dnv_cfg_t  cfg,
	output logic               name_valid
);
	import dnv_pkg::*;

	logic [8:0] total_q;
	logic [6:0] label_len_q;
	logic       starts_dash_q;
	logic       letters_only_q;
	logic [6:0] closed_len_q;
	logic       closed_letters_q;
	logic [1:0] tally_q;
	logic       broken_q;

	logic       is_dot, is_letter, is_digit, is_dash, allowed, do_close, bad_label;
	logic [8:0] total_n;
	logic [6:0] len_n, closed_len_n;
	logic       dash_n, letters_n, broken_n, closed_letters_n;
	logic [1:0] tally_n;

	always_comb begin
		is_dot    = word.character == CH_DOT;
		is_dash   = word.character == CH_DASH;
		is_letter = (word.character >= 8'h61 && word.character <= 8'h7A) ||
		            (word.character >= 8'h41 && word.character <= 8'h5A);
		is_digit  = word.character >= 8'h30 && word.character <= 8'h39;
		allowed   = is_letter | is_digit | is_dash | (word.character == CH_UNDER);

		total_n = (total_q == TOTAL_SAT) ? total_q : total_q + 9'd1;

		len_n     = label_len_q;
		dash_n    = starts_dash_q;
		letters_n = letters_only_q;
		broken_n  = broken_q;
		if (!is_dot) begin
			broken_n  = broken_q | ~allowed;
			dash_n    = starts_dash_q | ((label_len_q == 7'd0) & is_dash);
			letters_n = letters_only_q & is_letter;
			len_n     = (label_len_q == LABEL_SAT) ? label_len_q : label_len_q + 7'd1;
		end

		do_close         = is_dot | word.last_char;
		bad_label        = (len_n == 7'd0) | (len_n > {1'b0, cfg.max_label_length}) | dash_n;
		closed_len_n     = closed_len_q;
		closed_letters_n = closed_letters_q;
		tally_n          = tally_q;
		if (do_close) begin
			broken_n         = broken_n | bad_label;
			closed_len_n     = len_n;
			closed_letters_n = letters_n;
			tally_n          = (tally_q == TALLY_SAT) ? tally_q : tally_q + 2'd1;
			len_n            = 7'd0;
			dash_n           = 1'b0;
			letters_n        = 1'b1;
		end

		name_valid = ~broken_n &
		             (total_n >= {1'b0, cfg.min_total_length}) &
		             (total_n <= {1'b0, cfg.max_total_length}) &
		             (tally_n >= TALLY_MIN) &
		             closed_letters_n &
		             (closed_len_n != 7'd0) &
		             (closed_len_n >= {1'b0, cfg.min_tld_length});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q          <= '0;
			label_len_q      <= '0;
			starts_dash_q    <= 1'b0;
			letters_only_q   <= 1'b1;
			closed_len_q     <= '0;
			closed_letters_q <= 1'b0;
			tally_q          <= '0;
			broken_q         <= 1'b0;
		end else if (step) begin
			if (word.last_char) begin
				total_q          <= '0;
				label_len_q      <= '0;
				starts_dash_q    <= 1'b0;
				letters_only_q   <= 1'b1;
				closed_len_q     <= '0;
				closed_letters_q <= 1'b0;
				tally_q          <= '0;
				broken_q         <= 1'b0;
			end else begin
				total_q          <= total_n;
				label_len_q      <= len_n;
				starts_dash_q    <= dash_n;
				letters_only_q   <= letters_n;
				closed_len_q     <= closed_len_n;
				closed_letters_q <= closed_letters_n;
				tally_q          <= tally_n;
				broken_q         <= broken_n;
			end
		end
	end

endmodule

@@ rtl/domain_name_validator.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// domain_name_validator
// Checks host name syntax one character per word and gives one verdict per name.
//
//   channel   direction  handshake        payload
//   chars     in         valid / ready    character[7:0], last_char
//   verdict   out        valid / ready    name_valid
//   apb       in         psel / penable   paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One word enters each cycle unless a last word waits on a held verdict. A
// character is registered, checked in the next cycle against the name state,
// and a last word's verdict is loaded into the output register as it leaves.
// Reset clears the name state and loads the default limits.
// A waiting verdict stalls only a last word and the input behind it; other words keep flowing.
//------------------------------------------------------------------------------
module domain_name_validator (
	input  logic                         clk,
	input  logic                         arst_n,
	dnv_char_if.sink                     chars,
	dnv_verdict_if.source                verdict,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dnv_pkg::PADDR_W-1:0]  paddr,
	input  logic [dnv_pkg::PDATA_W-1:0]  pwdata,
	output logic [dnv_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import dnv_pkg::*;

	dnv_cfg_t  cfg;
	dnv_word_t word_s1;
	logic      valid_s1;
	logic      go_s1;
	logic      verdict_valid_q;
	logic      verdict_q;
	logic      check_valid;

	dnv_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dnv_name_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.word       (word_s1),
		.cfg        (cfg),
		.name_valid (check_valid)
	);

	assign go_s1 = valid_s1 & (~word_s1.last_char | ~verdict_valid_q | verdict.ready);
	assign chars.ready = ~valid_s1 | go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			word_s1.character <= chars.character;
			word_s1.last_char <= chars.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (go_s1 && word_s1.last_char) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && word_s1.last_char) begin
			verdict_q <= check_valid;
		end
	end

	assign verdict.valid      = verdict_valid_q;
	assign verdict.name_valid = verdict_q;

endmodule

@@ rtl/dnv_checker.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_checker
// Port-level checks on the domain name validator.
//------------------------------------------------------------------------------
module dnv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_name_valid,
	input logic pready
);

	// A verdict that is not taken stays offered with the same value.
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_name_valid))
		else $error("verdict dropped or changed while stalled");

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// A fresh verdict always comes from an accepted last word.
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without a last word");

	// A non-last word is always taken once the input register is free.
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last && !out_valid |=> in_ready)
		else $error("input stalled behind a non-last word");

endmodule

bind domain_name_validator dnv_checker u_dnv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (chars.valid),
	.in_ready       (chars.ready),
	.in_last        (chars.last_char),
	.out_valid      (verdict.valid),
	.out_ready      (verdict.ready),
	.out_name_valid (verdict.name_valid),
	.pready         (pready)
);

@@ tb/sv/dnv_verdict_checker.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dnv_verdict_checker
// Watches the character and verdict channels and the register port of the
// domain name validator. It keeps its own copy of the limits and of the
// name state, works out the verdict of every completed name, and compares
// each accepted verdict word against the oldest verdict still owed.
//------------------------------------------------------------------------------
module dnv_verdict_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	dnv_char_if                         chars,
	dnv_verdict_if                      verdict,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [dnv_pkg::PADDR_W-1:0] paddr,
	input  logic [dnv_pkg::PDATA_W-1:0] pwdata,
	output int                          fail_count,
	output int                          outstanding,
	output int                          valid_seen
);
	import dnv_pkg::*;

	dnv_cfg_t   limits;
	logic [8:0] name_len;
	logic [6:0] open_len;
	logic       open_dash;
	logic       open_alpha;
	logic [6:0] closed_len;
	logic       closed_alpha;
	logic [1:0] labels_closed;
	logic       name_broken;
	logic       owed_verdicts[$];

	function void clear_name();
		name_len      = '0;
		open_len      = '0;
		open_dash     = 1'b0;
		open_alpha    = 1'b1;
		closed_len    = '0;
		closed_alpha  = 1'b0;
		labels_closed = '0;
		name_broken   = 1'b0;
	endfunction

	function void close_label();
		if (open_len == 0 || open_len > 7'(limits.max_label_length) || open_dash) begin
			name_broken = 1'b1;
		end
		closed_len   = open_len;
		closed_alpha = open_alpha;
		if (labels_closed != TALLY_SAT) begin
			labels_closed++;
		end
		open_len   = '0;
		open_dash  = 1'b0;
		open_alpha = 1'b1;
	endfunction

	function void judge_char(input logic [7:0] ch, input logic is_last);
		logic alpha;
		logic num;
		logic ok;
		alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
		num   = ch >= "0" && ch <= "9";
		if (name_len != TOTAL_SAT) begin
			name_len++;
		end
		if (ch == CH_DOT) begin
			close_label();
		end else begin
			if (!(alpha || num || ch == CH_DASH || ch == CH_UNDER)) begin
				name_broken = 1'b1;
			end
			if (open_len == 0 && ch == CH_DASH) begin
				open_dash = 1'b1;
			end
			if (!alpha) begin
				open_alpha = 1'b0;
			end
			if (open_len != LABEL_SAT) begin
				open_len++;
			end
		end
		if (is_last) begin
			if (ch != CH_DOT) begin
				close_label();
			end
			ok = !name_broken
				&& name_len >= 9'(limits.min_total_length)
				&& name_len <= 9'(limits.max_total_length)
				&& labels_closed >= TALLY_MIN
				&& closed_alpha
				&& closed_len >= 7'd1
				&& closed_len >= 7'(limits.min_tld_length);
			owed_verdicts.insert(owed_verdicts.size(), ok);
			clear_name();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			limits = '{RST_MIN_TOTAL, RST_MAX_TOTAL, RST_MAX_LABEL, RST_MIN_TLD};
			clear_name();
			owed_verdicts.delete();
			fail_count = 0;
			valid_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MIN_TOTAL: limits.min_total_length = pwdata[7:0];
					REG_MAX_TOTAL: limits.max_total_length = pwdata[7:0];
					REG_MAX_LABEL: limits.max_label_length = pwdata[5:0];
					REG_MIN_TLD:   limits.min_tld_length   = pwdata[5:0];
					default: ;
				endcase
			end
			if (verdict.valid && verdict.ready) begin
				if (verdict.name_valid === 1'b1) begin
					valid_seen++;
				end
				if (owed_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: verdict word %b arrived with no name pending",
							$realtime, verdict.name_valid);
					end
				end else begin
					want = owed_verdicts.pop_front();
					if (verdict.name_valid !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: verdict mismatch, expected %b, got %b",
								$realtime, want, verdict.name_valid);
						end
					end
				end
			end
			if (chars.valid && chars.ready) begin
				judge_char(chars.character, chars.last_char);
			end
		end
		outstanding = owed_verdicts.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Feeds domain names, one character word at a time, into the validator and
// moves its limits through a series of settings, extremes among them. Names
// are mostly well formed with random content; the rest carry one flaw each or
// are plain noise. Both sides stall at random in the earlier phases, and the
// checker scores every verdict.
//------------------------------------------------------------------------------
module tb_top;
	import dnv_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_CHAR,
		FLAW_DASH_START,
		FLAW_EMPTY_LABEL,
		FLAW_TRAIL_DOT,
		FLAW_DIGIT_TLD,
		FLAW_ONE_LABEL,
		FLAW_NOISE
	} name_flaw_t;

	localparam int NUM_PHASES      = 10;
	localparam int WORDS_PER_PHASE = 165;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 fail_count;
	int                 outstanding;
	int                 valid_seen;
	int                 src_idle_pct = 19;
	int                 dst_idle_pct = 67;
	int                 words_sent   = 0;
	int                 names_sent   = 0;
	int                 settings_run = 1;
	int                 bigs_left    = 5;
	dnv_cfg_t           cur = '{RST_MIN_TOTAL, RST_MAX_TOTAL, RST_MAX_LABEL, RST_MIN_TLD};
	logic [7:0]         name_buf[$];

	dnv_char_if    chars_if ();
	dnv_verdict_if verdict_if ();

	domain_name_validator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.verdict (verdict_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	dnv_verdict_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars_if),
		.verdict     (verdict_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.valid_seen  (valid_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		verdict_if.ready = ($urandom_range(99, 0) >= dst_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [7:0] letter();
		logic [7:0] base;
		base = $urandom_range(1, 0) ? "a" : "A";
		return base + 8'($urandom_range(25, 0));
	endfunction

	function automatic logic [7:0] label_char();
		case ($urandom_range(9, 0))
			6, 7:    return "0" + 8'($urandom_range(9, 0));
			8:       return CH_DASH;
			9:       return CH_UNDER;
			default: return letter();
		endcase
	endfunction

	function automatic void append_char(input logic [7:0] c);
		name_buf.insert(name_buf.size(), c);
	endfunction

	task automatic send_word(input logic [7:0] ch, input logic is_last);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			chars_if.valid = 1'b0;
			@(negedge clk);
		end
		chars_if.valid     = 1'b1;
		chars_if.character = ch;
		chars_if.last_char = is_last;
		do @(posedge clk); while (!chars_if.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_name();
		foreach (name_buf[i]) begin
			send_word(name_buf[i], i == name_buf.size() - 1);
		end
		names_sent++;
	endtask

	task automatic send_text(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			append_char(s[i]);
		end
		send_name();
	endtask

	task automatic drain();
		chars_if.valid = 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input dnv_reg_t idx, input logic [7:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {24'($urandom()), val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apply_limits(input dnv_cfg_t c);
		drain();
		write_reg(REG_MIN_TOTAL, c.min_total_length);
		write_reg(REG_MAX_TOTAL, c.max_total_length);
		write_reg(REG_MAX_LABEL, {2'($urandom_range(3, 0)), c.max_label_length});
		write_reg(REG_MIN_TLD, {2'($urandom_range(3, 0)), c.min_tld_length});
		cur = c;
		settings_run++;
	endtask

	task automatic build_name(input bit big);
		int         n_labels;
		int         len;
		int         cap;
		int         tld_lo;
		int         pos;
		logic [7:0] c;
		name_flaw_t flaw;
		name_buf.delete();
		if (big) begin
			cap = 130;
		end else if (cur.max_label_length == 0) begin
			cap = 3;
		end else begin
			cap = (cur.max_label_length > 12) ? 12 : int'(cur.max_label_length);
		end
		n_labels = big ? $urandom_range(6, 3) : $urandom_range(4, 2);
		for (int l = 0; l < n_labels - 1; l++) begin
			if ($urandom_range(9, 0) == 0) begin
				len = int'(cur.max_label_length) + $urandom_range(1, 0);
			end else begin
				len = $urandom_range(cap, 1);
			end
			for (int k = 0; k < len; k++) begin
				c = label_char();
				if (k == 0 && c == CH_DASH) begin
					c = letter();
				end
				append_char(c);
			end
			append_char(CH_DOT);
		end
		tld_lo = (cur.min_tld_length > 1) ? int'(cur.min_tld_length) - 1 : 1;
		len = big ? $urandom_range(130, 60) : $urandom_range(int'(cur.min_tld_length) + 1, tld_lo);
		repeat (len) append_char(letter());

		pos = 0;
		while (pos < name_buf.size() && name_buf[pos] != CH_DOT) begin
			pos++;
		end
		flaw = FLAW_NONE;
		if ($urandom_range(99, 0) < 35) begin
			flaw = name_flaw_t'($urandom_range(int'(FLAW_NOISE), int'(FLAW_BAD_CHAR)));
		end
		case (flaw)
			FLAW_BAD_CHAR: begin
				case ($urandom_range(3, 0))
					0:       c = 8'($urandom_range(31, 0));
					1:       c = 8'($urandom_range(44, 32));
					2:       c = 8'($urandom_range(255, 128));
					default: c = 8'($urandom_range(64, 58));
				endcase
				name_buf[$urandom_range(name_buf.size() - 1, 0)] = c;
			end
			FLAW_DASH_START:  name_buf.insert($urandom_range(1, 0) ? 0 : pos + 1, CH_DASH);
			FLAW_EMPTY_LABEL: name_buf.insert($urandom_range(1, 0) ? 0 : pos, CH_DOT);
			FLAW_TRAIL_DOT:   append_char(CH_DOT);
			FLAW_DIGIT_TLD:   name_buf[name_buf.size() - 1] = "0" + 8'($urandom_range(9, 0));
			FLAW_ONE_LABEL: begin
				name_buf.delete();
				repeat ($urandom_range(12, 1)) append_char(letter());
			end
			FLAW_NOISE: begin
				name_buf.delete();
				repeat ($urandom_range(8, 1)) append_char(8'($urandom_range(255, 0)));
			end
			default: ;
		endcase
	endtask

	initial begin
		dnv_cfg_t plan[NUM_PHASES];
		int       phase_end;
		bit       first;
		bit       big;

		chars_if.valid     = 1'b0;
		chars_if.character = '0;
		chars_if.last_char = 1'b0;
		verdict_if.ready   = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;

		plan[0] = '{RST_MIN_TOTAL, RST_MAX_TOTAL, RST_MAX_LABEL, RST_MIN_TLD};
		plan[1] = '{8'd1, 8'd255, 6'd63, 6'd1};
		plan[2] = '{8'd255, 8'd255, 6'd63, 6'd63};
		plan[3] = '{8'd0, 8'd0, 6'd0, 6'd0};
		plan[4] = '{8'd3, 8'd20, 6'd8, 6'd3};
		plan[5] = '{8'd10, 8'd5, 6'd63, 6'd2};
		plan[6] = '{8'd1, 8'd40, 6'd4, 6'd0};
		for (int p = 7; p < NUM_PHASES; p++) begin
			plan[p] = '{8'($urandom_range(40, 1)), 8'($urandom_range(255, 10)),
				6'($urandom_range(63, 1)), 6'($urandom_range(6, 1))};
		end

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_text("ab.cd");
		send_text("-q.zz");
		send_text("a..bc");
		send_text("x_1.Az.");
		name_buf = {8'hFF};
		send_name();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				src_idle_pct = 19;
				dst_idle_pct = 67;
			end else if (p < 7) begin
				src_idle_pct = 67;
				dst_idle_pct = 19;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			if (p != 0) begin
				apply_limits(plan[p]);
			end
			phase_end = words_sent + WORDS_PER_PHASE;
			first = 1'b1;
			while (words_sent < phase_end) begin
				big = (bigs_left > 0)
					&& (first ? (p % 4 == 1) : ($urandom_range(59, 0) == 0));
				if (big) begin
					bigs_left--;
				end
				build_name(big);
				send_name();
				if ($urandom_range(19, 0) == 0) begin
					drain();
				end
				first = 1'b0;
			end
		end

		drain();
		repeat (10) @(negedge clk);

		$display("Sent %0d character words in %0d names under %0d limit settings.",
			words_sent, names_sent, settings_run);
		$display("%0d verdicts said valid; %0d mismatches counted.", valid_seen, fail_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/dnv_pkg.sv
rtl/dnv_ifs.sv
rtl/dnv_cfg_regs.sv
rtl/dnv_name_check.sv
rtl/domain_name_validator.sv
rtl/dnv_checker.sv
tb/sv/dnv_verdict_checker.sv
tb/sv/tb_top.sv
